FILE: rtl/cmf_pkg.sv
// shared types and constants of the chunked message framer
`default_nettype none
package cmf_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LENGTH_W    = 32;
   localparam int unsigned TYPE_W      = 40;
   localparam int unsigned CSR_DATA_W  = 40;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned COUNT_W     = 8;

   localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] LEN_CTRL  = 8'hFD;
   localparam logic [BYTE_W-1:0] TYPE_CTRL = 8'hFE;
   localparam logic [COUNT_W-1:0] CHUNK_LAST = 8'd252;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TYPE   = 2'd1;

   // positions in the byte sequence that one item can cause
   typedef logic [4:0] pos_type;
   localparam pos_type POS_HDR_MARK  = 5'd0;
   localparam pos_type POS_HDR_LCTRL = 5'd1;
   localparam pos_type POS_LEN_0     = 5'd2;
   localparam pos_type POS_LEN_1     = 5'd3;
   localparam pos_type POS_LEN_2     = 5'd4;
   localparam pos_type POS_LEN_3     = 5'd5;
   localparam pos_type POS_TYP_MARK  = 5'd6;
   localparam pos_type POS_TYP_CTRL  = 5'd7;
   localparam pos_type POS_TYP_0     = 5'd8;
   localparam pos_type POS_TYP_1     = 5'd9;
   localparam pos_type POS_TYP_2     = 5'd10;
   localparam pos_type POS_TYP_3     = 5'd11;
   localparam pos_type POS_TYP_4     = 5'd12;
   localparam pos_type POS_CHK_MARK  = 5'd13;
   localparam pos_type POS_CHK_NUM   = 5'd14;
   localparam pos_type POS_DATA      = 5'd15;
   localparam pos_type POS_TRL_A     = 5'd16;
   localparam pos_type POS_TRL_B     = 5'd17;

   // what one accepted beat has to emit
   typedef struct packed {
      logic                 header;
      logic                 no_payload;
      logic                 chunk_open;
      logic                 trailer;
      logic [COUNT_W-1:0]   chunk_number;
      logic [BYTE_W-1:0]    payload_byte;
   } plan_type;

endpackage
`default_nettype wire

FILE: rtl/chunked_message_framer_unit.sv
// top level of the chunked message framer
// Each accepted payload beat expands into 1 to 18 output bytes, sent one per
// clock while rsp_tready holds: the first beat of a frame adds a 13-byte
// header, the first beat of a chunk a 2-byte chunk mark, and the last beat a
// 2-byte trailer. The input holds one beat while its bytes go out and takes
// the next one as the last byte of the current beat is emitted. The single
// output sequencer sends one byte a cycle unless rsp_tready stalls it. The
// beat is registered in the planner, then each byte in the emitter's output
// register. The csr port is always ready; write it only while the block is idle.
`default_nettype none
module chunked_message_framer_unit #(
   parameter int unsigned CHUNK_BYTES = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: payload_byte[7:0]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,
   // tdata: out_byte[7:0]; tlast: run_last; tuser: frame_end
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cmf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cmf_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [cmf_pkg::LENGTH_W-1:0] message_length;
   logic [cmf_pkg::TYPE_W-1:0]   message_type;
   logic                         plan_valid;
   logic                         plan_done;
   cmf_pkg::plan_type            plan;

   cmf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .message_length (message_length),
      .message_type   (message_type)
   );

   cmf_planner #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_planner (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .message_length (message_length),
      .plan_valid     (plan_valid),
      .plan           (plan),
      .plan_done      (plan_done)
   );

   cmf_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .plan_valid     (plan_valid),
      .plan           (plan),
      .plan_done      (plan_done),
      .message_length (message_length),
      .message_type   (message_type),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: rtl/cmf_csr.sv
// configuration registers of the framer
`default_nettype none
module cmf_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [cmf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cmf_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [cmf_pkg::LENGTH_W-1:0]           message_length,
   output logic [cmf_pkg::TYPE_W-1:0]             message_type
);

   logic [cmf_pkg::LENGTH_W-1:0] length_ff, length_in;
   logic [cmf_pkg::TYPE_W-1:0]   type_ff, type_in;
   logic                         write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      length_in = length_ff;
      type_in   = type_ff;
      if (write) begin
         case (csr_index)
            cmf_pkg::REG_LENGTH: length_in = csr_data[cmf_pkg::LENGTH_W-1:0];
            cmf_pkg::REG_TYPE:   type_in   = csr_data[cmf_pkg::TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         type_ff   <= '0;
      end else begin
         length_ff <= length_in;
         type_ff   <= type_in;
      end
   end

   assign message_length = length_ff;
   assign message_type   = type_ff;

endmodule
`default_nettype wire

FILE: rtl/cmf_planner.sv
// frame state and input register: decides what each beat emits
`default_nettype none
module cmf_planner #(
   parameter int unsigned CHUNK_BYTES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [cmf_pkg::BYTE_W-1:0]      req_tdata,
   input  wire logic [cmf_pkg::LENGTH_W-1:0]    message_length,
   output logic                                 plan_valid,
   output cmf_pkg::plan_type                    plan,
   input  wire logic                            plan_done
);

   localparam int unsigned FILL_W = $clog2(CHUNK_BYTES + 1);

   logic [cmf_pkg::LENGTH_W-1:0] taken_ff, taken_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;
   logic [cmf_pkg::COUNT_W-1:0]  number_ff, number_in;
   logic                         plan_valid_ff, plan_valid_in;
   cmf_pkg::plan_type            plan_ff, plan_in;
   logic                         accept;
   logic                         first;
   logic                         empty_msg;
   logic                         finish;

   assign req_tready = !plan_valid_ff || plan_done;
   assign accept     = req_tvalid && req_tready;

   assign first     = (taken_ff == '0);
   assign empty_msg = first && (message_length == '0);
   assign finish    = ({1'b0, taken_ff} + 33'd1) >= {1'b0, message_length};

   always_comb begin
      taken_in  = taken_ff;
      fill_in   = fill_ff;
      number_in = number_ff;
      plan_in   = plan_ff;
      if (accept) begin
         plan_in.header       = first;
         plan_in.no_payload   = empty_msg;
         plan_in.chunk_open   = (fill_ff == '0);
         plan_in.trailer      = empty_msg || finish;
         plan_in.chunk_number = number_ff;
         plan_in.payload_byte = req_tdata;
         if (!empty_msg) begin
            if (fill_ff == FILL_W'(CHUNK_BYTES - 1)) begin
               fill_in   = '0;
               number_in = (number_ff == cmf_pkg::CHUNK_LAST) ? '0
                         : number_ff + cmf_pkg::COUNT_W'(1);
            end else begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (finish) begin
               taken_in  = '0;
               fill_in   = '0;
               number_in = '0;
            end else begin
               taken_in = taken_ff + cmf_pkg::LENGTH_W'(1);
            end
         end
      end
   end

   always_comb begin
      plan_valid_in = plan_valid_ff;
      if (accept) begin
         plan_valid_in = 1'b1;
      end else if (plan_done) begin
         plan_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff      <= '0;
         fill_ff       <= '0;
         number_ff     <= '0;
         plan_valid_ff <= 1'b0;
      end else begin
         taken_ff      <= taken_in;
         fill_ff       <= fill_in;
         number_ff     <= number_in;
         plan_valid_ff <= plan_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

   assign plan_valid = plan_valid_ff;
   assign plan       = plan_ff;

endmodule
`default_nettype wire

FILE: rtl/cmf_emitter.sv
// byte sequencer and output register
`default_nettype none
module cmf_emitter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            plan_valid,
   input  wire cmf_pkg::plan_type               plan,
   output logic                                 plan_done,
   input  wire logic [cmf_pkg::LENGTH_W-1:0]    message_length,
   input  wire logic [cmf_pkg::TYPE_W-1:0]      message_type,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [cmf_pkg::BYTE_W-1:0]           rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);

   cmf_pkg::pos_type           pos_ff, pos_in, cur_pos, start_pos, next_pos;
   logic                       busy_ff, busy_in;
   logic                       out_valid_ff, out_valid_in;
   logic [cmf_pkg::BYTE_W-1:0] byte_ff, byte_in, cur_byte;
   logic                       last_ff, last_in, cur_last;
   logic                       end_ff, end_in, cur_end;
   logic                       emit;

   assign emit = plan_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      if (plan.header) begin
         start_pos = cmf_pkg::POS_HDR_MARK;
      end else if (plan.chunk_open) begin
         start_pos = cmf_pkg::POS_CHK_MARK;
      end else begin
         start_pos = cmf_pkg::POS_DATA;
      end
   end

   assign cur_pos = busy_ff ? pos_ff : start_pos;

   always_comb begin
      case (cur_pos)
         cmf_pkg::POS_TYP_4: begin
            if (plan.no_payload) begin
               next_pos = cmf_pkg::POS_TRL_A;
            end else if (plan.chunk_open) begin
               next_pos = cmf_pkg::POS_CHK_MARK;
            end else begin
               next_pos = cmf_pkg::POS_DATA;
            end
         end
         default: next_pos = cur_pos + 5'd1;
      endcase
   end

   assign cur_last = (cur_pos == cmf_pkg::POS_TRL_B)
                  || ((cur_pos == cmf_pkg::POS_DATA) && !plan.trailer);
   assign cur_end  = (cur_pos == cmf_pkg::POS_TRL_B);

   always_comb begin
      case (cur_pos)
         cmf_pkg::POS_HDR_LCTRL: cur_byte = cmf_pkg::LEN_CTRL;
         cmf_pkg::POS_LEN_0:     cur_byte = message_length[7:0];
         cmf_pkg::POS_LEN_1:     cur_byte = message_length[15:8];
         cmf_pkg::POS_LEN_2:     cur_byte = message_length[23:16];
         cmf_pkg::POS_LEN_3:     cur_byte = message_length[31:24];
         cmf_pkg::POS_TYP_CTRL:  cur_byte = cmf_pkg::TYPE_CTRL;
         cmf_pkg::POS_TYP_0:     cur_byte = message_type[7:0];
         cmf_pkg::POS_TYP_1:     cur_byte = message_type[15:8];
         cmf_pkg::POS_TYP_2:     cur_byte = message_type[23:16];
         cmf_pkg::POS_TYP_3:     cur_byte = message_type[31:24];
         cmf_pkg::POS_TYP_4:     cur_byte = message_type[39:32];
         cmf_pkg::POS_CHK_NUM:   cur_byte = plan.chunk_number;
         cmf_pkg::POS_DATA:      cur_byte = plan.payload_byte;
         default:                cur_byte = cmf_pkg::MARK_BYTE;
      endcase
   end

   assign plan_done = emit && cur_last;

   always_comb begin
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      if (emit) begin
         busy_in      = !cur_last;
         pos_in       = cur_last ? cmf_pkg::POS_HDR_MARK : next_pos;
         out_valid_in = 1'b1;
         byte_in      = cur_byte;
         last_in      = cur_last;
         end_in       = cur_end;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= cmf_pkg::POS_HDR_MARK;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      end_ff  <= end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without last beat");

   a_busy_needs_plan: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> plan_valid)
      else $error("sequencer busy without a plan");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cmf_pkg::POS_TRL_B)
      else $error("sequence position out of range");

   a_stall_holds_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(pos_ff) && $stable(busy_ff))
      else $error("sequencer advanced under stall");

endmodule
`default_nettype wire
